// ===== rtl/core/cbse_pkg.sv =====
// ----------------------------------------------------------------------------
// cbse_pkg: shared types and constants for the cubic B-spline segment evaluator
// Fixed-point widths, operation and kind codes, divider command and helpers.
// ----------------------------------------------------------------------------
package cbse_pkg;

  localparam int unsigned PT_W       = 32;
  localparam int unsigned COEF_W     = 40;
  localparam int unsigned ACC_W      = 44;
  localparam int unsigned U_W        = 17;
  localparam int unsigned MUL_W      = ACC_W + U_W;
  localparam int unsigned COMB_W     = 38;
  localparam int unsigned DIV_W      = 40;
  localparam int unsigned DIV_DIGITS = 8;
  localparam int unsigned DIV_STEPS  = DIV_W / DIV_DIGITS;
  localparam int unsigned N_COEF     = 12;

  localparam logic [U_W-1:0] U_ONE = 17'h10000;

  localparam logic REG_START = 1'b0;
  localparam logic REG_INV   = 1'b1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_POS  = 2'd0,
    KIND_VEL  = 2'd1,
    KIND_ACC  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef struct packed {
    logic load;
    logic step;
  } div_cmd_t;

  // coefficient k of axis ax lives at 3*k + ax
  function automatic logic [3:0] coef_index(input logic [1:0] k, input logic [1:0] ax);
    coef_index = {1'b0, k, 1'b0} + {2'b00, k} + {2'b00, ax};
  endfunction

  // floor((32*r + 1) / 3) for the remainder of the divide by three
  function automatic logic [4:0] rem_frac(input logic [1:0] r);
    case (r)
      2'd1:    rem_frac = 5'd11;
      2'd2:    rem_frac = 5'd21;
      default: rem_frac = 5'd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/cubic_bspline_segment_eval.sv =====
// Load beat: input stalled while the 12 coefficients are recomputed, each through the divide-by-3 unit.
// Evaluate beat: the parameter is normalised on the shared multiplier (low half, high half, finish),
// then per axis a load step, one multiplier pass per Horner step and a store; the unused kind takes
// no Horner step. The result is registered once all three axes are stored and the output register is free.
// One item at a time; the output register lets the next beat enter while a result waits.
// Reset: idle, start 0, inverse length 1.0, control points and coefficients zero.
// ----------------------------------------------------------------------------
// cubic_bspline_segment_eval: uniform cubic B-spline segment evaluator, 3-D
// Control point loads recompute per-axis coefficients; evaluations return
// position or derivatives in saturated Q16.16 with an in-bounds flag.
// ----------------------------------------------------------------------------
module cubic_bspline_segment_eval import cbse_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic [1:0]             point_index_i,
  input  logic signed [PT_W-1:0] point_x_i,
  input  logic signed [PT_W-1:0] point_y_i,
  input  logic signed [PT_W-1:0] point_z_i,
  input  logic signed [PT_W-1:0] curve_param_i,
  input  logic [1:0]             eval_kind_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [PT_W-1:0] out_x_o,
  output logic signed [PT_W-1:0] out_y_o,
  output logic signed [PT_W-1:0] out_z_o,
  output logic                   in_bounds_o
);

  localparam int unsigned DSTEP_W = $clog2(DIV_STEPS);
  localparam logic signed [COMB_W-1:0] COMB_BIAS = 38'sd103079215104;
  localparam logic signed [DIV_W:0]    QUOT_BIAS = 41'sd34359738368;

  typedef enum logic [3:0] {
    S_IDLE, S_COMB, S_DIV, S_WCOEF, S_NORM_LO, S_NORM_HI, S_NORM_FIN,
    S_LOAD, S_STEP, S_STORE, S_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic signed [PT_W-1:0]    start_q;
  logic [PT_W-1:0]           inv_q;
  logic signed [PT_W-1:0]    cp_x_q [4];
  logic signed [PT_W-1:0]    cp_y_q [4];
  logic signed [PT_W-1:0]    cp_z_q [4];
  logic signed [COEF_W-1:0]  coef_q [N_COEF];

  logic signed [PT_W-1:0]    param_q, param_d;
  kind_e                     kind_q, kind_d;
  logic [1:0]                k_q, k_d;
  logic [1:0]                ax_q, ax_d;
  logic [DSTEP_W-1:0]        dstep_q, dstep_d;
  logic [1:0]                j_q, j_d;
  logic [47:0]               plo_q, plo_d;
  logic [63:0]               prod_q, prod_d;
  logic [U_W-1:0]            u_q, u_d;
  logic                      inb_q, inb_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [PT_W-1:0]    res_q [3];
  logic signed [PT_W-1:0]    res_d [3];
  logic                      out_valid_q, out_valid_d;
  logic signed [PT_W-1:0]    out_x_q, out_x_d;
  logic signed [PT_W-1:0]    out_y_q, out_y_d;
  logic signed [PT_W-1:0]    out_z_q, out_z_d;
  logic                      out_inb_q, out_inb_d;

  logic                      in_acc;
  logic                      cfg_wr;
  logic signed [PT_W-1:0]    pt [4];
  logic signed [COMB_W-1:0]  pe [4];
  logic signed [COMB_W-1:0]  mix;
  logic signed [COMB_W-1:0]  comb;
  logic signed [COMB_W-1:0]  biased;
  logic [DIV_W-1:0]          dividend;
  logic [DIV_W-1:0]          quot;
  logic [1:0]                rem;
  logic signed [DIV_W:0]     quot_off;
  logic signed [COEF_W-1:0]  coef_new;
  logic [3:0]                coef_wr_idx;
  logic [3:0]                coef_rd_idx;
  logic signed [COEF_W-1:0]  coef_rd;
  logic signed [ACC_W-1:0]   coef_ext;
  logic signed [ACC_W-1:0]   addend;
  div_cmd_t                  div_cmd;
  logic signed [32:0]        diff;
  logic signed [32:0]        neg_diff;
  logic                      neg;
  logic [31:0]               mag;
  logic signed [ACC_W-1:0]   mul_a;
  logic [U_W-1:0]            mul_b;
  logic signed [MUL_W-1:0]   mul_p;
  logic signed [MUL_W-1:0]   rsum;
  logic signed [ACC_W-1:0]   rounded;
  logic [32:0]               u_rnd;
  logic                      over;
  logic [1:0]                last_j;
  logic signed [ACC_W:0]     sround;
  logic signed [ACC_W-6:0]   scaled;
  logic                      fits;
  logic signed [PT_W-1:0]    sat_val;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_wr     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_INV) ? inv_q : start_q;

  // coefficient combination for (k, axis)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (ax_q)
        2'd0:    pt[i] = cp_x_q[i];
        2'd1:    pt[i] = cp_y_q[i];
        default: pt[i] = cp_z_q[i];
      endcase
      pe[i] = COMB_W'(pt[i]);
    end
    case (k_q)
      2'd0: begin
        mix  = pe[1] - pe[2];
        comb = pe[3] - pe[0] + (mix <<< 1) + mix;
      end
      2'd1: begin
        mix  = pe[0] - (pe[1] <<< 1) + pe[2];
        comb = (mix <<< 1) + mix;
      end
      2'd2: begin
        mix  = pe[2] - pe[0];
        comb = (mix <<< 1) + mix;
      end
      default: begin
        mix  = pe[0] + pe[2];
        comb = mix + (pe[1] <<< 2);
      end
    endcase
    biased   = comb + COMB_BIAS;
    dividend = {{(DIV_W-COMB_W){1'b0}}, biased};
  end

  cbse_div3 u_div3 (
    .clk_i      (clk_i),
    .cmd_i      (div_cmd),
    .dividend_i (dividend),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign quot_off    = $signed({1'b0, quot}) - QUOT_BIAS;
  assign coef_new    = {quot_off[COEF_W-6:0], rem_frac(rem)};
  assign coef_wr_idx = coef_index(k_q, ax_q);
  assign coef_rd_idx = (state_q == S_LOAD) ? coef_index(2'd0, ax_q)
                                           : coef_index(j_q + 2'd1, ax_q);
  assign coef_rd     = coef_q[coef_rd_idx];
  assign coef_ext    = ACC_W'(coef_rd);

  // normalisation and shared multiplier
  assign diff     = {param_q[PT_W-1], param_q} - {start_q[PT_W-1], start_q};
  assign neg_diff = -diff;
  assign neg      = diff[32];
  assign mag      = neg ? neg_diff[31:0] : diff[31:0];

  always_comb begin
    if (state_q == S_STEP) begin
      mul_a = acc_q;
    end else begin
      mul_a = $signed({{(ACC_W-32){1'b0}}, mag});
    end
    case (state_q)
      S_NORM_LO: mul_b = {1'b0, inv_q[15:0]};
      S_NORM_HI: mul_b = {1'b0, inv_q[31:16]};
      default:   mul_b = u_q;
    endcase
  end

  cbse_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  assign rsum    = mul_p + MUL_W'(32768);
  assign rounded = rsum[ACC_W+15:16];
  assign u_rnd   = prod_q[32:0] + 33'd32768;
  assign over    = (|prod_q[63:33]) || (prod_q[32] && (|prod_q[31:0]));

  always_comb begin
    case (kind_q)
      KIND_POS: last_j = 2'd2;
      KIND_VEL: last_j = 2'd1;
      default:  last_j = 2'd0;
    endcase
    if ((j_q == 2'd0) && (kind_q != KIND_POS)) begin
      addend = coef_ext <<< 1;
    end else begin
      addend = coef_ext;
    end
  end

  // Q22.22 to Q16.16 with saturation
  assign sround  = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(32);
  assign scaled  = sround[ACC_W:6];
  assign fits    = (&scaled[ACC_W-6:PT_W-1]) || !(|scaled[ACC_W-6:PT_W-1]);
  assign sat_val = fits ? scaled[PT_W-1:0]
                        : (scaled[ACC_W-6] ? 32'sh8000_0000 : 32'sh7fff_ffff);

  always_comb begin
    state_d     = state_q;
    param_d     = param_q;
    kind_d      = kind_q;
    k_d         = k_q;
    ax_d        = ax_q;
    dstep_d     = dstep_q;
    j_d         = j_q;
    plo_d       = plo_q;
    prod_d      = prod_q;
    u_d         = u_q;
    inb_d       = inb_q;
    acc_d       = acc_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_z_d     = out_z_q;
    out_inb_d   = out_inb_q;
    div_cmd     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == OP_LOAD) begin
            k_d     = 2'd0;
            ax_d    = 2'd0;
            state_d = S_COMB;
          end else begin
            param_d = curve_param_i;
            kind_d  = kind_e'(eval_kind_i);
            state_d = S_NORM_LO;
          end
        end
      end
      S_COMB: begin
        div_cmd.load = 1'b1;
        dstep_d      = '0;
        state_d      = S_DIV;
      end
      S_DIV: begin
        div_cmd.step = 1'b1;
        dstep_d      = dstep_q + 1'b1;
        if (dstep_q == DSTEP_W'(DIV_STEPS - 1)) begin
          state_d = S_WCOEF;
        end
      end
      S_WCOEF: begin
        if (ax_q == 2'd2) begin
          ax_d = 2'd0;
          if (k_q == 2'd3) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = S_COMB;
          end
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_COMB;
        end
      end
      S_NORM_LO: begin
        plo_d   = mul_p[47:0];
        state_d = S_NORM_HI;
      end
      S_NORM_HI: begin
        prod_d  = {16'b0, plo_q} + {mul_p[47:0], 16'b0};
        state_d = S_NORM_FIN;
      end
      S_NORM_FIN: begin
        if (neg) begin
          u_d   = '0;
          inb_d = (prod_q == '0);
        end else if (over) begin
          u_d   = U_ONE;
          inb_d = 1'b0;
        end else begin
          u_d   = u_rnd[32:16];
          inb_d = 1'b1;
        end
        ax_d    = 2'd0;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        j_d = 2'd0;
        case (kind_q)
          KIND_POS: acc_d = coef_ext;
          KIND_VEL: acc_d = (coef_ext <<< 1) + coef_ext;
          KIND_ACC: acc_d = (coef_ext <<< 2) + (coef_ext <<< 1);
          default:  acc_d = '0;
        endcase
        state_d = (kind_q == KIND_NONE) ? S_STORE : S_STEP;
      end
      S_STEP: begin
        acc_d = addend + rounded;
        j_d   = j_q + 2'd1;
        if (j_q == last_j) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        res_d[ax_q] = sat_val;
        if (ax_q == 2'd2) begin
          state_d = S_DONE;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_x_d     = res_q[0];
          out_y_d     = res_q[1];
          out_z_d     = res_q[2];
          out_inb_d   = inb_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      param_q     <= '0;
      kind_q      <= KIND_POS;
      k_q         <= '0;
      ax_q        <= '0;
      dstep_q     <= '0;
      j_q         <= '0;
      plo_q       <= '0;
      prod_q      <= '0;
      u_q         <= '0;
      inb_q       <= 1'b0;
      acc_q       <= '0;
      res_q       <= '{default: '0};
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_z_q     <= '0;
      out_inb_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      param_q     <= param_d;
      kind_q      <= kind_d;
      k_q         <= k_d;
      ax_q        <= ax_d;
      dstep_q     <= dstep_d;
      j_q         <= j_d;
      plo_q       <= plo_d;
      prod_q      <= prod_d;
      u_q         <= u_d;
      inb_q       <= inb_d;
      acc_q       <= acc_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_x_q     <= out_x_d;
      out_y_q     <= out_y_d;
      out_z_q     <= out_z_d;
      out_inb_q   <= out_inb_d;
    end
  end

  // configuration, control points and coefficients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      inv_q   <= 32'h0001_0000;
      cp_x_q  <= '{default: '0};
      cp_y_q  <= '{default: '0};
      cp_z_q  <= '{default: '0};
      coef_q  <= '{default: '0};
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_START) begin
          start_q <= pwdata;
        end else begin
          inv_q <= pwdata;
        end
      end
      if (in_acc && (operation_i == OP_LOAD)) begin
        cp_x_q[point_index_i] <= point_x_i;
        cp_y_q[point_index_i] <= point_y_i;
        cp_z_q[point_index_i] <= point_z_i;
      end
      if (state_q == S_WCOEF) begin
        coef_q[coef_wr_idx] <= coef_new;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign in_bounds_o = out_inb_q;

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result beat raised outside the done state");

  a_load_recompute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (operation_i == OP_LOAD)) |=> (state_q == S_COMB))
    else $error("load beat did not start coefficient recompute");

  a_u_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (u_q <= U_ONE))
    else $error("normalised parameter above one");

  a_mid_inb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_LOAD) && (u_q != '0) && (u_q != U_ONE)) |-> inb_q)
    else $error("interior parameter flagged out of bounds");

endmodule

// ===== rtl/core/cbse_mul.sv =====
// ----------------------------------------------------------------------------
// cbse_mul: shared signed-by-unsigned multiplier
// Serves the parameter normalisation halves and every Horner step.
// ----------------------------------------------------------------------------
module cbse_mul import cbse_pkg::*; (
  input  logic signed [ACC_W-1:0] a_i,
  input  logic        [U_W-1:0]   b_i,
  output logic signed [MUL_W-1:0] p_o
);

  assign p_o = MUL_W'(a_i) * MUL_W'($signed({1'b0, b_i}));

endmodule

// ===== rtl/core/cbse_div3.sv =====
// ----------------------------------------------------------------------------
// cbse_div3: iterative divide-by-three unit
// Retires several quotient digits per step from a non-negative dividend.
// ----------------------------------------------------------------------------
module cbse_div3 import cbse_pkg::*; (
  input  logic             clk_i,
  input  div_cmd_t         cmd_i,
  input  logic [DIV_W-1:0] dividend_i,
  output logic [DIV_W-1:0] quot_o,
  output logic [1:0]       rem_o
);

  logic [DIV_W-1:0]      work_q, work_d;
  logic [1:0]            rem_q, rem_d;
  logic [DIV_DIGITS-1:0] qbits;
  logic [2:0]            trial;
  logic [1:0]            part;

  always_comb begin
    part  = rem_q;
    qbits = '0;
    trial = '0;
    for (int i = DIV_DIGITS - 1; i >= 0; i--) begin
      trial    = {part, work_q[DIV_W - DIV_DIGITS + i]};
      qbits[i] = (trial >= 3'd3);
      part     = qbits[i] ? 2'(trial - 3'd3) : trial[1:0];
    end
    work_d = work_q;
    rem_d  = rem_q;
    if (cmd_i.load) begin
      work_d = dividend_i;
      rem_d  = '0;
    end else if (cmd_i.step) begin
      work_d = {work_q[DIV_W-DIV_DIGITS-1:0], qbits};
      rem_d  = part;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

  assign quot_o = work_q;
  assign rem_o  = rem_q;

endmodule

// ===== tb/sv/tb_cubic_bspline_segment_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bspline_segment_eval: self-checking bench for the B-spline evaluator
// Drives control point loads and evaluations with random gaps and output
// stalls. A built-in fixed-point predictor tracks points, coefficients and
// both registers, and each result beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_cubic_bspline_segment_eval;
  import cbse_pkg::*;

  localparam int          CYCLE_LIMIT      = 1_000_000;
  localparam int          SETTLE_CYCLES    = 100;
  localparam int          RANDOM_PER_PHASE = 170;
  localparam logic [31:0] PT_MAX           = 32'h7FFF_FFFF;
  localparam logic [31:0] PT_MIN           = 32'h8000_0000;
  localparam logic [31:0] Q_ONE            = 32'h0001_0000;
  localparam longint      SAT_HI           = 64'sd2147483647;
  localparam longint      SAT_LO           = -64'sd2147483648;

  typedef struct {
    op_e                op;
    logic [1:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] param;
    kind_e              kind;
  } beat_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               inb;
  } spline_result_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     psel          = 1'b0;
  logic                     penable       = 1'b0;
  logic                     pwrite        = 1'b0;
  logic [2:0]               paddr         = '0;
  logic [31:0]              pwdata        = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic                     operation_i   = 1'b0;
  logic [1:0]               point_index_i = '0;
  logic signed [31:0]       point_x_i     = '0;
  logic signed [31:0]       point_y_i     = '0;
  logic signed [31:0]       point_z_i     = '0;
  logic signed [31:0]       curve_param_i = '0;
  logic [1:0]               eval_kind_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic signed [31:0]       out_x_o;
  logic signed [31:0]       out_y_o;
  logic signed [31:0]       out_z_o;
  logic                     in_bounds_o;

  longint                   seg_start = 0;
  longint unsigned          inv_len   = 64'd65536;
  longint                   ctrl_pts [12];
  longint                   coef_q22 [12];

  beat_t                    pending_beats [$];
  spline_result_t           results_due [$];
  beat_t                    cur_beat;
  spline_result_t           due;
  logic                     beat_held    = 1'b0;
  int                       in_idle_left = 0;
  int                       stall_left   = 0;
  int                       calm_left [2] = '{0, 0};
  int                       mismatch_count = 0;
  int                       cycle_count    = 0;

  cubic_bspline_segment_eval DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .curve_param_i (curve_param_i),
    .eval_kind_i   (eval_kind_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .in_bounds_o   (in_bounds_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint round_div6(longint n);
    longint m;
    longint q;
    m = n + 3;
    q = m / 6;
    if ((m % 6) != 0 && m < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint scale_by_u(longint acc, longint u);
    return (acc * u + 32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] q22_to_q16(longint q);
    longint v;
    v = (q + 32) >>> 6;
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[31:0];
  endfunction

  function automatic void refresh_coefs();
    longint p0, p1, p2, p3;
    for (int ax = 0; ax < 3; ax++) begin
      p0 = ctrl_pts[ax];
      p1 = ctrl_pts[3 + ax];
      p2 = ctrl_pts[6 + ax];
      p3 = ctrl_pts[9 + ax];
      coef_q22[ax]     = round_div6((-p0 + 3 * p1 - 3 * p2 + p3) * 64);
      coef_q22[3 + ax] = round_div6((3 * p0 - 6 * p1 + 3 * p2) * 64);
      coef_q22[6 + ax] = round_div6((-3 * p0 + 3 * p2) * 64);
      coef_q22[9 + ax] = round_div6((p0 + 4 * p1 + p2) * 64);
    end
  endfunction

  function automatic void apply_beat(beat_t b);
    longint          diff;
    longint unsigned mag;
    longint unsigned prod;
    longint          u;
    longint          acc;
    longint          ca, cb, cc, cd;
    logic            inb;
    logic signed [31:0] res [3];
    spline_result_t  r;
    if (b.op == OP_LOAD) begin
      ctrl_pts[int'(b.idx) * 3]     = longint'(b.x);
      ctrl_pts[int'(b.idx) * 3 + 1] = longint'(b.y);
      ctrl_pts[int'(b.idx) * 3 + 2] = longint'(b.z);
      refresh_coefs();
      return;
    end
    diff = longint'(b.param) - seg_start;
    mag  = (diff < 0) ? -diff : diff;
    prod = mag * inv_len;
    inb  = 1'b1;
    if (diff < 0) begin
      u = 0;
      if (prod != 0) inb = 1'b0;
    end else if (prod > 64'h1_0000_0000) begin
      u   = longint'(U_ONE);
      inb = 1'b0;
    end else begin
      u = longint'((prod + 64'd32768) >> 16);
    end
    for (int ax = 0; ax < 3; ax++) begin
      ca = coef_q22[ax];
      cb = coef_q22[3 + ax];
      cc = coef_q22[6 + ax];
      cd = coef_q22[9 + ax];
      case (b.kind)
        KIND_POS: begin
          acc = cb + scale_by_u(ca, u);
          acc = cc + scale_by_u(acc, u);
          acc = cd + scale_by_u(acc, u);
        end
        KIND_VEL: begin
          acc = 2 * cb + scale_by_u(3 * ca, u);
          acc = cc + scale_by_u(acc, u);
        end
        KIND_ACC: acc = 2 * cb + scale_by_u(6 * ca, u);
        default:  acc = 0;
      endcase
      res[ax] = q22_to_q16(acc);
    end
    r.x   = res[0];
    r.y   = res[1];
    r.z   = res[2];
    r.inb = inb;
    results_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic int pick_idle_len(int side);
    int unsigned r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic beat_t make_beat(op_e op, logic [1:0] idx, logic [31:0] x,
                                      logic [31:0] y, logic [31:0] z,
                                      logic [31:0] param, kind_e kind);
    beat_t b;
    b.op    = op;
    b.idx   = idx;
    b.x     = x;
    b.y     = y;
    b.z     = z;
    b.param = param;
    b.kind  = kind;
    return b;
  endfunction

  function automatic logic [31:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    if (pick < 85) return $urandom;
    case ($urandom_range(0, 3))
      0:       return PT_MAX;
      1:       return PT_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic beat_t random_beat();
    beat_t           b;
    int unsigned     pick;
    longint unsigned span;
    longint          off;
    b.op  = ($urandom_range(0, 99) < 25) ? OP_LOAD : OP_EVAL;
    b.idx = 2'($urandom);
    b.x   = random_coord();
    b.y   = random_coord();
    b.z   = random_coord();
    pick  = $urandom_range(0, 99);
    if (pick < 33)      b.kind = KIND_POS;
    else if (pick < 63) b.kind = KIND_VEL;
    else if (pick < 93) b.kind = KIND_ACC;
    else                b.kind = KIND_NONE;
    pick = $urandom_range(0, 99);
    if (inv_len == 0 || pick < 15) begin
      b.param = $urandom;
    end else begin
      span = 64'h1_0000_0000 / inv_len;
      if (pick < 22) off = longint'(span) + longint'($urandom_range(0, 1));
      else off = longint'($urandom_range(0, 1000)) * longint'(span + span / 4) / 1000
                 - longint'(span / 8);
      b.param = 32'(seg_start + off);
    end
    return b;
  endfunction

  task automatic write_register(input logic which, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == REG_START) seg_start = longint'($signed(value));
    else                    inv_len   = value;
  endtask

  task automatic wait_until_quiet();
    while (pending_beats.size() != 0 || beat_held || results_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] st;
    logic [31:0] iv;
    for (int i = 0; i < 12; i++) begin
      ctrl_pts[i] = 0;
      coef_q22[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_beats.push_back(make_beat(OP_EVAL, 2'd3, PT_MAX, PT_MIN, '1, '0, KIND_POS));
    pending_beats.push_back(make_beat(OP_LOAD, 2'd0, PT_MAX, PT_MAX, PT_MAX, '0, KIND_POS));
    pending_beats.push_back(make_beat(OP_LOAD, 2'd1, PT_MIN, PT_MIN, PT_MIN, '1, KIND_NONE));
    pending_beats.push_back(make_beat(OP_LOAD, 2'd2, PT_MAX, PT_MIN, '0, '0, KIND_VEL));
    pending_beats.push_back(make_beat(OP_LOAD, 2'd3, PT_MIN, PT_MAX, Q_ONE, '0, KIND_ACC));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, 32'h8000, KIND_POS));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, 32'h8000, KIND_VEL));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, 32'h8000, KIND_ACC));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, 32'h8000, KIND_NONE));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd1, '0, '0, '0, '0, KIND_POS));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd2, '0, '0, '0, Q_ONE, KIND_VEL));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, 32'h1_0001, KIND_ACC));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, '1, KIND_POS));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, PT_MAX, KIND_POS));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, PT_MIN, KIND_VEL));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, -32'sd5, KIND_NONE));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, 32'h7FFF, KIND_POS));
    pending_beats.push_back(make_beat(OP_LOAD, 2'd0, '0, '0, '0, '1, KIND_NONE));
    pending_beats.push_back(make_beat(OP_EVAL, 2'd3, '1, PT_MAX, PT_MIN, 32'h4000, KIND_VEL));
    wait_until_quiet();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       begin st = '0;     iv = '0;                                 end
        1:       begin st = PT_MIN; iv = '1;                                 end
        2:       begin st = PT_MAX; iv = 32'd1;                              end
        3:       begin st = $urandom; iv = Q_ONE;                            end
        default: begin st = $urandom; iv = $urandom_range(32'h4000, 32'h8_0000); end
      endcase
      write_register(REG_START, st);
      write_register(REG_INV, iv);
      if (p == 0) begin
        pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, -32'sh2_0000, KIND_VEL));
        pending_beats.push_back(make_beat(OP_EVAL, 2'd0, '0, '0, '0, 32'h3_0000, KIND_POS));
      end
      repeat (RANDOM_PER_PHASE) pending_beats.push_back(random_beat());
      wait_until_quiet();
    end

    if (mismatch_count == 0) begin
      $display("** cubic_bspline_segment_eval: PASSED **");
    end else begin
      $display("** cubic_bspline_segment_eval: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_beat(cur_beat);
        beat_held    = 1'b0;
        in_idle_left = pick_idle_len(0);
      end
      if (!beat_held) begin
        if (in_idle_left > 0) begin
          in_idle_left--;
        end else if (pending_beats.size() != 0) begin
          cur_beat      = pending_beats.pop_front();
          beat_held     = 1'b1;
          operation_i   <= cur_beat.op;
          point_index_i <= cur_beat.idx;
          point_x_i     <= cur_beat.x;
          point_y_i     <= cur_beat.y;
          point_z_i     <= cur_beat.z;
          curve_param_i <= cur_beat.param;
          eval_kind_i   <= cur_beat.kind;
        end
      end
      in_valid_i <= beat_held;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result beat with no evaluation outstanding");
          mismatch_count++;
        end else begin
          due = results_due.pop_front();
          if (out_x_o !== due.x) begin
            $error("out_x: expected %0d, got %0d", due.x, out_x_o);
            mismatch_count++;
          end
          if (out_y_o !== due.y) begin
            $error("out_y: expected %0d, got %0d", due.y, out_y_o);
            mismatch_count++;
          end
          if (out_z_o !== due.z) begin
            $error("out_z: expected %0d, got %0d", due.z, out_z_o);
            mismatch_count++;
          end
          if (in_bounds_o !== due.inb) begin
            $error("in_bounds: expected %0d, got %0d", due.inb, in_bounds_o);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        if ($urandom_range(0, 3) == 0) stall_left = pick_idle_len(1);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** cubic_bspline_segment_eval: FAILED **");
      $finish;
    end
  end

endmodule
